// ===== rtl/fourfsk_rrc_modulator_core_macros.svh =====
// assertion helpers for the 4fsk rrc modulator core
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef FOURFSK_RRC_MODULATOR_CORE_MACROS_SVH
`define FOURFSK_RRC_MODULATOR_CORE_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define FRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define FRM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/ffsk_rrc_pkg.sv =====
// types, constants and tables for the 4fsk rrc modulator core
// no dependencies
`timescale 1ns / 1ps

package ffsk_rrc_pkg;

  localparam int SYMBOLS_PER_BYTE = 4;
  localparam int SYM_CNT_W        = $clog2(SYMBOLS_PER_BYTE);
  localparam int MUL_W            = 16;
  localparam int PROD_W           = 2 * MUL_W;
  localparam int Q_SHIFT          = 15;

  // dibit codes
  localparam logic [1:0] DIBIT_NEG_LO = 2'b00;
  localparam logic [1:0] DIBIT_NEG_HI = 2'b01;
  localparam logic [1:0] DIBIT_POS_LO = 2'b10;
  localparam logic [1:0] DIBIT_POS_HI = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYM,
    ST_PUSH,
    ST_MAC,
    ST_FIN,
    ST_EMIT
  } state_e;

  function automatic logic signed [MUL_W-1:0] level_of(input logic [1:0] dibit);
    logic signed [MUL_W-1:0] lvl;
    unique case (dibit)
      DIBIT_NEG_LO: lvl = -16'sd454;
      DIBIT_NEG_HI: lvl = -16'sd1362;
      DIBIT_POS_LO: lvl = 16'sd454;
      DIBIT_POS_HI: lvl = 16'sd1362;
    endcase
    return lvl;
  endfunction

  // 41-tap rrc prototype at indices 4 to 44, zero outside the table
  function automatic logic signed [MUL_W-1:0] coef_at(input logic [15:0] idx);
    logic signed [MUL_W-1:0] c;
    case (idx)
      16'd4:   c = 16'sd850;
      16'd5:   c = 16'sd219;
      16'd6:   c = -16'sd720;
      16'd7:   c = -16'sd1548;
      16'd8:   c = -16'sd1795;
      16'd9:   c = -16'sd1172;
      16'd10:  c = 16'sd237;
      16'd11:  c = 16'sd1927;
      16'd12:  c = 16'sd3120;
      16'd13:  c = 16'sd3073;
      16'd14:  c = 16'sd1447;
      16'd15:  c = -16'sd1431;
      16'd16:  c = -16'sd4544;
      16'd17:  c = -16'sd6442;
      16'd18:  c = -16'sd5735;
      16'd19:  c = -16'sd1633;
      16'd20:  c = 16'sd5651;
      16'd21:  c = 16'sd14822;
      16'd22:  c = 16'sd23810;
      16'd23:  c = 16'sd30367;
      16'd24:  c = 16'sd32767;
      16'd25:  c = 16'sd30367;
      16'd26:  c = 16'sd23810;
      16'd27:  c = 16'sd14822;
      16'd28:  c = 16'sd5651;
      16'd29:  c = -16'sd1633;
      16'd30:  c = -16'sd5735;
      16'd31:  c = -16'sd6442;
      16'd32:  c = -16'sd4544;
      16'd33:  c = -16'sd1431;
      16'd34:  c = 16'sd1447;
      16'd35:  c = 16'sd3073;
      16'd36:  c = 16'sd3120;
      16'd37:  c = 16'sd1927;
      16'd38:  c = 16'sd237;
      16'd39:  c = -16'sd1172;
      16'd40:  c = -16'sd1795;
      16'd41:  c = -16'sd1548;
      16'd42:  c = -16'sd720;
      16'd43:  c = 16'sd219;
      16'd44:  c = 16'sd850;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/fourfsk_rrc_modulator_core.sv =====
// channel | signals                          | moves
// input   | in_valid_i/in_ready_o            | data_byte_i, silence_i
// output  | out_valid_o/out_ready_i          | sample_o, last_o
// config  | cfg_we_i (no wait)               | cfg_wdata_i -> amp_level
//
// one shared 16x16 multiplier does the symbol scaling and all filter taps
// each sample runs a mac sweep over the taps, a finish step and an emit step
// each symbol adds a scale step and a push step before its samples
// in_ready_o is high only when idle; a stalled output holds the sequencer
// reset is asynchronous active low and clears the symbol history, amp_level goes to 128
// depends on ffsk_rrc_pkg and fourfsk_rrc_modulator_core_macros.svh
`timescale 1ns / 1ps
`include "fourfsk_rrc_modulator_core_macros.svh"

module fourfsk_rrc_modulator_core
  import ffsk_rrc_pkg::*;
#(
  parameter int INTERP_FACTOR  = 5,
  parameter int TAPS_PER_PHASE = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               silence_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               last_o
);

  localparam int J_W    = $clog2(INTERP_FACTOR);
  localparam int K_W    = $clog2(TAPS_PER_PHASE);
  localparam int CIDX_W = $clog2(INTERP_FACTOR * TAPS_PER_PHASE);
  localparam int ACC_W  = PROD_W + $clog2(TAPS_PER_PHASE) + 1;
  localparam int EXT_W  = ACC_W - PROD_W;

  localparam logic signed [ACC_W-1:0]  ACC_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0]  ACC_MIN  = ACC_W'(-32768);
  localparam logic signed [PROD_W-1:0] PROD_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] PROD_MIN = PROD_W'(-32768);

  state_e state_q, state_d;

  logic [7:0]               amp_level_q;
  logic [7:0]               byte_q, byte_d;
  logic                     silence_q, silence_d;
  logic [SYM_CNT_W-1:0]     sym_cnt_q, sym_cnt_d;
  logic [J_W-1:0]           j_q, j_d;
  logic [K_W-1:0]           k_q, k_d;
  logic [CIDX_W-1:0]        cidx_q, cidx_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     prod_vld_q, prod_vld_d;
  logic signed [15:0]       hist_q [TAPS_PER_PHASE];
  logic signed [15:0]       hist_d [TAPS_PER_PHASE];
  logic signed [15:0]       sample_q, sample_d;
  logic                     last_q, last_d;
  logic                     out_valid_q, out_valid_d;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] sym_shift;
  logic signed [15:0]       sym_sat;
  logic signed [ACC_W-1:0]  acc_fin, acc_shift;
  logic                     last_phase, last_sym;

  // shared multiplier, registered
  assign prod_d = mul_a * mul_b;

  assign sym_shift  = prod_q >>> Q_SHIFT;
  assign acc_fin    = acc_q + {{EXT_W{prod_q[PROD_W-1]}}, prod_q};
  assign acc_shift  = acc_fin >>> Q_SHIFT;
  assign last_phase = (j_q == J_W'(INTERP_FACTOR - 1));
  assign last_sym   = (sym_cnt_q == SYM_CNT_W'(SYMBOLS_PER_BYTE - 1));

  always_comb begin
    priority if (sym_shift > PROD_MAX) begin
      sym_sat = 16'sh7fff;
    end else if (sym_shift < PROD_MIN) begin
      sym_sat = -16'sh8000;
    end else begin
      sym_sat = sym_shift[15:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    silence_d   = silence_q;
    sym_cnt_d   = sym_cnt_q;
    j_d         = j_q;
    k_d         = k_q;
    cidx_d      = cidx_q;
    acc_d       = acc_q;
    prod_vld_d  = 1'b0;
    hist_d      = hist_q;
    sample_d    = sample_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    mul_a       = hist_q[k_q];
    mul_b       = coef_at(16'(cidx_q));
    in_ready_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          byte_d    = data_byte_i;
          silence_d = silence_i;
          sym_cnt_d = '0;
          state_d   = ST_SYM;
        end
      end
      ST_SYM: begin
        // level times gain, gain = amp_level * 128
        mul_a   = level_of(byte_q[7:6]);
        mul_b   = {1'b0, amp_level_q, 7'd0};
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        for (int i = 0; i < TAPS_PER_PHASE - 1; i++) begin
          hist_d[i] = hist_q[i + 1];
        end
        hist_d[TAPS_PER_PHASE - 1] = silence_q ? 16'sd0 : sym_sat;
        byte_d  = {byte_q[5:0], 2'b00};
        j_d     = '0;
        k_d     = '0;
        cidx_d  = CIDX_W'(INTERP_FACTOR - 1);
        acc_d   = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        // product of the previous tap is registered and is added in the next cycle
        prod_vld_d = 1'b1;
        if (prod_vld_q) begin
          acc_d = acc_fin;
        end
        cidx_d = cidx_q + CIDX_W'(INTERP_FACTOR);
        if (k_q == K_W'(TAPS_PER_PHASE - 1)) begin
          k_d     = '0;
          state_d = ST_FIN;
        end else begin
          k_d = k_q + K_W'(1);
        end
      end
      ST_FIN: begin
        priority if (acc_shift > ACC_MAX) begin
          sample_d = 16'sh7fff;
        end else if (acc_shift < ACC_MIN) begin
          sample_d = -16'sh8000;
        end else begin
          sample_d = acc_shift[15:0];
        end
        last_d      = last_phase && last_sym;
        out_valid_d = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (last_phase) begin
            if (last_sym) begin
              state_d = ST_IDLE;
            end else begin
              sym_cnt_d = sym_cnt_q + SYM_CNT_W'(1);
              state_d   = ST_SYM;
            end
          end else begin
            j_d     = j_q + J_W'(1);
            k_d     = '0;
            cidx_d  = CIDX_W'(INTERP_FACTOR - 2) - CIDX_W'(j_q);
            acc_d   = '0;
            state_d = ST_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      amp_level_q <= 8'd128;
      sym_cnt_q   <= '0;
      j_q         <= '0;
      k_q         <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      for (int i = 0; i < TAPS_PER_PHASE; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        amp_level_q <= cfg_wdata_i;
      end
      sym_cnt_q   <= sym_cnt_d;
      j_q         <= j_d;
      k_q         <= k_d;
      prod_vld_q  <= prod_vld_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      hist_q      <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    silence_q <= silence_d;
    cidx_q    <= cidx_d;
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    sample_q  <= sample_d;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

  `FRM_ASSERT(a_busy_excl, in_ready_o |-> !out_valid_o, "ready while a sample is pending")
  `FRM_ASSERT(a_last_idle, out_valid_o && out_ready_i && last_o |=> in_ready_o, "no idle after last")
  `FRM_ASSERT(a_take_busy, in_valid_i && in_ready_o |=> !in_ready_o, "ready right after a request")
  `FRM_ASSERT_NEVER(a_tap_range, k_q > K_W'(TAPS_PER_PHASE - 1), "tap index out of range")

endmodule
